>>> src/pfpc_pkg.sv
// ----------------------------------------------------------------------------
// pfpc_pkg: shared types and constants for the polygon footprint path check
// Transaction payloads, the edge record handed along the cell chain, and the
// fixed codes and constants of the block.
// ----------------------------------------------------------------------------
`default_nettype none

package pfpc_pkg;

    localparam int VTX_W     = 12;   // vertex coordinate, whole units
    localparam int COORD_W   = 16;   // foot coordinate, Q12.4
    localparam int RAD_W     = 12;   // radius, Q8.4
    localparam int PROBE_W   = 17;   // probe point, Q.4, never wraps
    localparam int VCOUNT_W  = 7;
    localparam int STEP_W    = 12;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DAT_W = 12;
    localparam int DIV_W     = 17;
    localparam int NUM_PROBES = 6;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_VERTEX_COUNT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_STEP  = 1'b1;

    localparam logic [STEP_W-1:0] DEFAULT_STEP = 12'd48;
    localparam logic [7:0]        DIAG_NUM     = 8'd179;

    typedef struct packed {
        logic                      op;
        logic [5:0]                vertex_index;
        logic signed [VTX_W-1:0]   vertex_x;
        logic signed [VTX_W-1:0]   vertex_y;
        logic signed [COORD_W-1:0] start_x;
        logic signed [COORD_W-1:0] start_y;
        logic signed [COORD_W-1:0] end_x;
        logic signed [COORD_W-1:0] end_y;
        logic [RAD_W-1:0]          radius_x;
        logic [RAD_W-1:0]          radius_y;
        logic                      allow_outside_start;
    } item_t;

    typedef struct packed {
        logic passes;
        logic was_write;
    } result_t;

    // one polygon side, current vertex a and previous vertex b, in Q.4
    typedef struct packed {
        logic                      valid;
        logic                      last;
        logic signed [COORD_W-1:0] ax;
        logic signed [COORD_W-1:0] ay;
        logic signed [COORD_W-1:0] bx;
        logic signed [COORD_W-1:0] by;
    } link_t;

endpackage

`default_nettype wire

>>> src/pfpc_cell.sv
// ----------------------------------------------------------------------------
// pfpc_cell: one probe point of the footprint
// Holds a probe point and its crossing parity, tests each polygon side that
// passes by, and hands the side on to its neighbor in the next cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module pfpc_cell (
    input  wire                            clk,
    input  wire                            rst_n,
    input  wire                            load,
    input  wire signed [pfpc_pkg::PROBE_W-1:0] probe_x,
    input  wire signed [pfpc_pkg::PROBE_W-1:0] probe_y,
    input  pfpc_pkg::link_t                link_in,
    output pfpc_pkg::link_t                link_out,
    output logic                           in_poly
);
    import pfpc_pkg::*;

    logic signed [PROBE_W-1:0] px_reg;
    logic signed [PROBE_W-1:0] py_reg;
    logic                      parity_reg;
    link_t                     link_reg;

    logic signed [17:0] dxa;
    logic signed [17:0] dxb;
    logic signed [17:0] dyp;
    logic signed [17:0] dd;
    logic signed [35:0] lhs;
    logic signed [35:0] rhs;
    logic               straddle;
    logic               crossing;

    always_comb
    begin
        dxa = 18'(px_reg) - 18'(link_in.ax);
        dxb = 18'(link_in.bx) - 18'(link_in.ax);
        dyp = 18'(py_reg) - 18'(link_in.ay);
        dd  = 18'(link_in.by) - 18'(link_in.ay);
        lhs = 36'(dxa) * 36'(dd);
        rhs = 36'(dxb) * 36'(dyp);
        straddle = (18'(link_in.ay) > 18'(py_reg)) != (18'(link_in.by) > 18'(py_reg));
        crossing = straddle && ((dd > 18'sd0) ? (lhs < rhs) : (lhs > rhs));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            link_reg   <= '0;
            parity_reg <= 1'b0;
        end
        else
        begin
            link_reg <= link_in;
            if (load)
                parity_reg <= 1'b0;
            else if (link_in.valid && crossing)
                parity_reg <= ~parity_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            px_reg <= probe_x;
            py_reg <= probe_y;
        end
    end

    assign link_out = link_reg;
    assign in_poly  = parity_reg;

endmodule

`default_nettype wire

>>> src/pfpc_div.sv
// ----------------------------------------------------------------------------
// pfpc_div: unsigned restoring divider
// One quotient bit per cycle; done pulses with quotient and remainder ready.
// ----------------------------------------------------------------------------
`default_nettype none

module pfpc_div (
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire                          start,
    input  wire [pfpc_pkg::DIV_W-1:0]    dividend,
    input  wire [pfpc_pkg::DIV_W-1:0]    divisor,
    output logic                         done,
    output logic [pfpc_pkg::DIV_W-1:0]   quotient,
    output logic [pfpc_pkg::DIV_W-1:0]   remainder
);
    import pfpc_pkg::*;

    localparam int CNT_W = $clog2(DIV_W + 1);

    logic [DIV_W-1:0] quo_reg;
    logic [DIV_W-1:0] rem_reg;
    logic [DIV_W-1:0] den_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             run_reg;
    logic             done_reg;

    logic [DIV_W:0] trial;
    logic [DIV_W:0] diff;
    logic           ge;

    always_comb
    begin
        trial = {rem_reg, quo_reg[DIV_W-1]};
        diff  = trial - {1'b0, den_reg};
        ge    = trial >= {1'b0, den_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= CNT_W'(DIV_W);
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            den_reg <= divisor;
        end
        else if (run_reg)
        begin
            rem_reg <= ge ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
            quo_reg <= {quo_reg[DIV_W-2:0], ge};
        end
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

`default_nettype wire

>>> src/polygon_footprint_path_check.sv
// ----------------------------------------------------------------------------
// polygon_footprint_path_check: walking footprint check against a polygon
// Stores polygon vertices and tests whether a footprint sampled along a
// segment stays inside the polygon (even-odd ray crossing per probe point).
// ----------------------------------------------------------------------------
//  channel  | direction | handshake                | payload
//  item     | in        | item_valid / item_stall  | item   (pfpc_pkg::item_t)
//  result   | out       | result_valid/result_stall| result (pfpc_pkg::result_t)
//  cfg      | in        | cfg_write                | cfg_index, cfg_data
//
//  A vertex write goes straight to the emit step. A query first runs its setup
//  (squares, 17-step square root, three divisions; only the length division
//  for a zero-length segment), then up to n+1 footprint tests, n samples,
//  joined by an advance step each, and an emit step. One transaction is in
//  work at a time; a finished result waits in the output register while the
//  next item is taken. Reset clears control state only.
// ----------------------------------------------------------------------------
`default_nettype none

module polygon_footprint_path_check #(
    parameter int MAX_VERTICES = 64,
    parameter int MAX_SAMPLES  = 1024
) (
    input  wire                                  clk,
    input  wire                                  rst_n,
    input  wire                                  item_valid,
    output logic                                 item_stall,
    input  pfpc_pkg::item_t                      item,
    output logic                                 result_valid,
    input  wire                                  result_stall,
    output pfpc_pkg::result_t                    result,
    input  wire                                  cfg_write,
    input  wire [pfpc_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  wire [pfpc_pkg::CFG_DAT_W-1:0]        cfg_data
);
    import pfpc_pkg::*;

    localparam int AW = $clog2(MAX_VERTICES);
    localparam int NW = $clog2(MAX_SAMPLES + 1);

    typedef enum logic [3:0] {
        S_IDLE, S_SQR, S_SUM, S_SQRT, S_MGO, S_MWAIT, S_XGO, S_XWAIT,
        S_YGO, S_YWAIT, S_FOOT, S_WALK, S_EVAL, S_ADV, S_EMIT
    } state_t;

    state_t state_reg;

    // configuration
    logic [VCOUNT_W-1:0] vcount_reg;
    logic [STEP_W-1:0]   step_reg;

    // query payload and setup arithmetic
    item_t                    item_reg;
    logic signed [DIV_W-1:0]  dx_reg;
    logic signed [DIV_W-1:0]  dy_reg;
    logic [33:0]              sqx_reg;
    logic [33:0]              sqy_reg;
    logic [33:0]              src_reg;
    logic [18:0]              srem_reg;
    logic [DIV_W-1:0]         root_reg;
    logic [4:0]               iter_reg;
    logic [RAD_W-1:0]         gx_reg;
    logic [RAD_W-1:0]         gy_reg;
    logic [NW-1:0]            n_reg;
    logic signed [17:0]       stepqx_reg;
    logic signed [17:0]       stepqy_reg;
    logic [NW:0]              steprx_reg;
    logic [NW:0]              stepry_reg;
    logic signed [17:0]       qx_reg;
    logic signed [17:0]       qy_reg;
    logic [NW:0]              rx_reg;
    logic [NW:0]              ry_reg;
    logic [NW-1:0]            k_reg;
    logic                     mode_end_reg;
    logic                     entered_reg;
    logic                     pend_pass_reg;
    logic                     pend_write_reg;
    logic                     result_valid_reg;
    result_t                  result_reg;

    // edge walk
    logic [7:0]               icnt_reg;
    logic                     rd_valid_reg;
    logic                     rd_first_reg;
    logic                     rd_last_reg;
    logic [23:0]              prev_reg;
    logic [23:0]              rdata_reg;
    logic [23:0]              vtab [MAX_VERTICES];

    logic                     accept;
    logic                     wr_en;
    logic                     rd_en;
    logic [AW-1:0]            rd_addr;
    logic [VCOUNT_W-1:0]      ncnt;
    logic                     few_verts;
    logic [STEP_W-1:0]        stepq;

    logic [20:0]              sq_cur;
    logic [20:0]              sq_trial;
    logic                     sq_ge;
    logic [DIV_W-1:0]         m_len;

    logic                     div_start;
    logic [DIV_W-1:0]         div_dividend;
    logic [DIV_W-1:0]         div_divisor;
    logic                     div_done;
    logic [DIV_W-1:0]         div_q;
    logic [DIV_W-1:0]         div_r;
    logic                     r_nz;
    logic [DIV_W-1:0]         n_raw;
    logic [DIV_W-1:0]         abs_dx;
    logic [DIV_W-1:0]         abs_dy;
    logic signed [17:0]       fq;
    logic [NW-1:0]            frem;
    logic                     dneg;

    logic [NW+1:0]            sum_rx;
    logic [NW+1:0]            sum_ry;
    logic [NW+1:0]            two_n;
    logic                     wrap_x;
    logic                     wrap_y;

    logic signed [PROBE_W-1:0] foot_x;
    logic signed [PROBE_W-1:0] foot_y;
    logic signed [PROBE_W-1:0] rxe;
    logic signed [PROBE_W-1:0] rye;
    logic signed [PROBE_W-1:0] gxe;
    logic signed [PROBE_W-1:0] gye;
    logic signed [PROBE_W-1:0] probe_x [NUM_PROBES];
    logic signed [PROBE_W-1:0] probe_y [NUM_PROBES];
    logic [NUM_PROBES-1:0]     cell_inside;
    link_t                     chain [NUM_PROBES+1];
    logic                      cell_load;
    logic                      foot_in;
    logic                      emit_go;

    assign accept     = item_valid && !item_stall;
    assign item_stall = (state_reg != S_IDLE);
    assign wr_en      = accept && (item.op == OP_WRITE)
                        && (32'(item.vertex_index) < MAX_VERTICES);

    assign ncnt = (32'(vcount_reg) > MAX_VERTICES) ? VCOUNT_W'(MAX_VERTICES) : vcount_reg;
    assign few_verts = ncnt < VCOUNT_W'(3);
    assign stepq     = (step_reg == '0) ? DEFAULT_STEP : step_reg;

    // output register is free when empty or being taken this cycle
    assign emit_go = (state_reg == S_EMIT) && (!result_valid_reg || !result_stall);

    // square root, two radicand bits per step
    always_comb
    begin
        sq_cur   = {srem_reg, src_reg[33:32]};
        sq_trial = {2'b00, root_reg, 2'b01};
        sq_ge    = sq_cur >= sq_trial;
        m_len    = root_reg + DIV_W'(srem_reg != '0);
    end

    // divider operands and floor correction
    always_comb
    begin
        abs_dx = dx_reg[DIV_W-1] ? DIV_W'(-dx_reg) : DIV_W'(dx_reg);
        abs_dy = dy_reg[DIV_W-1] ? DIV_W'(-dy_reg) : DIV_W'(dy_reg);
        div_start    = (state_reg == S_MGO) || (state_reg == S_XGO) || (state_reg == S_YGO);
        div_dividend = (state_reg == S_MGO) ? m_len
                     : ((state_reg == S_XGO) ? abs_dx : abs_dy);
        div_divisor  = (state_reg == S_MGO) ? DIV_W'(stepq) : DIV_W'(n_reg);
        r_nz  = div_r != '0;
        n_raw = div_q + DIV_W'(r_nz);
        dneg  = (state_reg == S_XWAIT) ? dx_reg[DIV_W-1] : dy_reg[DIV_W-1];
        if (!dneg)
        begin
            fq   = 18'(div_q);
            frem = NW'(div_r);
        end
        else if (r_nz)
        begin
            fq   = -(18'(div_q) + 18'sd1);
            frem = NW'(DIV_W'(n_reg) - div_r);
        end
        else
        begin
            fq   = -18'(div_q);
            frem = '0;
        end
    end

    // sample advance
    always_comb
    begin
        two_n  = {1'b0, n_reg, 1'b0};
        sum_rx = {1'b0, rx_reg} + {1'b0, steprx_reg};
        sum_ry = {1'b0, ry_reg} + {1'b0, stepry_reg};
        wrap_x = sum_rx >= two_n;
        wrap_y = sum_ry >= two_n;
    end

    // foot position and probe points
    always_comb
    begin
        if (mode_end_reg)
        begin
            foot_x = PROBE_W'(item_reg.end_x);
            foot_y = PROBE_W'(item_reg.end_y);
        end
        else
        begin
            foot_x = PROBE_W'(18'(item_reg.start_x) + qx_reg);
            foot_y = PROBE_W'(18'(item_reg.start_y) + qy_reg);
        end
        rxe = $signed({5'b0, item_reg.radius_x});
        rye = $signed({5'b0, item_reg.radius_y});
        gxe = $signed({5'b0, gx_reg});
        gye = $signed({5'b0, gy_reg});
        probe_x[0] = foot_x;        probe_y[0] = foot_y;
        probe_x[1] = foot_x - rxe;  probe_y[1] = foot_y;
        probe_x[2] = foot_x + rxe;  probe_y[2] = foot_y;
        probe_x[3] = foot_x;        probe_y[3] = foot_y - rye;
        probe_x[4] = foot_x - gxe;  probe_y[4] = foot_y - gye;
        probe_x[5] = foot_x + gxe;  probe_y[5] = foot_y - gye;
    end

    assign cell_load = (state_reg == S_FOOT);
    assign foot_in   = few_verts || (&cell_inside);

    // vertex memory: the previous vertex first, then every vertex in order
    assign rd_en   = (state_reg == S_WALK) && (icnt_reg <= 8'(ncnt));
    assign rd_addr = (icnt_reg == '0) ? AW'(ncnt - 1'b1) : AW'(icnt_reg - 1'b1);

    always_ff @(posedge clk)
    begin
        if (wr_en)
            vtab[AW'(item.vertex_index)] <= {item.vertex_x, item.vertex_y};
        if (rd_en)
            rdata_reg <= vtab[rd_addr];
        if (rd_valid_reg)
            prev_reg <= rdata_reg;
    end

    always_comb
    begin
        chain[0].valid = rd_valid_reg && !rd_first_reg;
        chain[0].last  = rd_last_reg;
        chain[0].ax    = $signed({rdata_reg[23:12], 4'b0});
        chain[0].ay    = $signed({rdata_reg[11:0], 4'b0});
        chain[0].bx    = $signed({prev_reg[23:12], 4'b0});
        chain[0].by    = $signed({prev_reg[11:0], 4'b0});
    end

    for (genvar i = 0; i < NUM_PROBES; i++)
    begin : g_cell
        pfpc_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .load     (cell_load),
            .probe_x  (probe_x[i]),
            .probe_y  (probe_y[i]),
            .link_in  (chain[i]),
            .link_out (chain[i+1]),
            .in_poly  (cell_inside[i])
        );
    end

    pfpc_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .done      (div_done),
        .quotient  (div_q),
        .remainder (div_r)
    );

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vcount_reg <= '0;
            step_reg   <= DEFAULT_STEP;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_VERTEX_COUNT: vcount_reg <= cfg_data[VCOUNT_W-1:0];
                REG_SAMPLE_STEP:  step_reg   <= cfg_data[STEP_W-1:0];
                default:          ;
            endcase
        end
    end

    // walk read control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            icnt_reg     <= '0;
            rd_valid_reg <= 1'b0;
            rd_first_reg <= 1'b0;
            rd_last_reg  <= 1'b0;
        end
        else
        begin
            rd_valid_reg <= rd_en;
            rd_first_reg <= icnt_reg == '0;
            rd_last_reg  <= icnt_reg == 8'(ncnt);
            if (state_reg == S_FOOT)
                icnt_reg <= '0;
            else if (rd_en)
                icnt_reg <= icnt_reg + 1'b1;
        end
    end

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            result_valid_reg <= 1'b0;
            result_reg       <= '0;
            pend_pass_reg    <= 1'b0;
            pend_write_reg   <= 1'b0;
            mode_end_reg     <= 1'b0;
            entered_reg      <= 1'b0;
            iter_reg         <= '0;
            k_reg            <= '0;
        end
        else
        begin
            if (emit_go)
                result_valid_reg <= 1'b1;
            else if (result_valid_reg && !result_stall)
                result_valid_reg <= 1'b0;

            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        item_reg <= item;
                        dx_reg   <= DIV_W'(item.end_x) - DIV_W'(item.start_x);
                        dy_reg   <= DIV_W'(item.end_y) - DIV_W'(item.start_y);
                        if (item.op == OP_WRITE)
                        begin
                            pend_pass_reg  <= 1'b0;
                            pend_write_reg <= 1'b1;
                            state_reg      <= S_EMIT;
                        end
                        else
                        begin
                            pend_write_reg <= 1'b0;
                            state_reg      <= S_SQR;
                        end
                    end
                end
                S_SQR:
                begin
                    sqx_reg <= 34'(34'(dx_reg) * 34'(dx_reg));
                    sqy_reg <= 34'(34'(dy_reg) * 34'(dy_reg));
                    gx_reg  <= RAD_W'((20'(item_reg.radius_x) * 20'(DIAG_NUM) + 20'd128) >> 8);
                    gy_reg  <= RAD_W'((20'(item_reg.radius_y) * 20'(DIAG_NUM) + 20'd128) >> 8);
                    state_reg <= S_SUM;
                end
                S_SUM:
                begin
                    src_reg   <= sqx_reg + sqy_reg;
                    srem_reg  <= '0;
                    root_reg  <= '0;
                    iter_reg  <= 5'd17;
                    state_reg <= S_SQRT;
                end
                S_SQRT:
                begin
                    srem_reg <= sq_ge ? 19'(sq_cur - sq_trial) : 19'(sq_cur);
                    root_reg <= {root_reg[DIV_W-2:0], sq_ge};
                    src_reg  <= {src_reg[31:0], 2'b00};
                    iter_reg <= iter_reg - 1'b1;
                    if (iter_reg == 5'd1)
                        state_reg <= S_MGO;
                end
                S_MGO:
                    state_reg <= S_MWAIT;
                S_MWAIT:
                begin
                    if (div_done)
                    begin
                        n_reg <= (32'(n_raw) > MAX_SAMPLES) ? NW'(MAX_SAMPLES) : NW'(n_raw);
                        qx_reg      <= '0;
                        qy_reg      <= '0;
                        k_reg       <= '0;
                        entered_reg <= 1'b0;
                        if (n_raw == '0)
                        begin
                            mode_end_reg <= 1'b1;
                            state_reg    <= S_FOOT;
                        end
                        else
                        begin
                            mode_end_reg <= 1'b0;
                            state_reg    <= S_XGO;
                        end
                    end
                end
                S_XGO:
                    state_reg <= S_XWAIT;
                S_XWAIT:
                begin
                    if (div_done)
                    begin
                        stepqx_reg <= fq;
                        steprx_reg <= {frem, 1'b0};
                        state_reg  <= S_YGO;
                    end
                end
                S_YGO:
                    state_reg <= S_YWAIT;
                S_YWAIT:
                begin
                    if (div_done)
                    begin
                        stepqy_reg <= fq;
                        stepry_reg <= {frem, 1'b0};
                        rx_reg     <= {1'b0, n_reg};
                        ry_reg     <= {1'b0, n_reg};
                        state_reg  <= S_FOOT;
                    end
                end
                S_FOOT:
                    state_reg <= few_verts ? S_EVAL : S_WALK;
                S_WALK:
                begin
                    if (chain[NUM_PROBES].valid && chain[NUM_PROBES].last)
                        state_reg <= S_EVAL;
                end
                S_EVAL:
                begin
                    if (mode_end_reg)
                    begin
                        pend_pass_reg <= foot_in;
                        state_reg     <= S_EMIT;
                    end
                    else if (k_reg == '0)
                    begin
                        entered_reg <= foot_in;
                        if (!foot_in && !item_reg.allow_outside_start)
                        begin
                            pend_pass_reg <= 1'b0;
                            state_reg     <= S_EMIT;
                        end
                        else
                            state_reg <= S_ADV;
                    end
                    else if (!foot_in && entered_reg)
                    begin
                        // left the polygon after entering
                        pend_pass_reg <= 1'b0;
                        state_reg     <= S_EMIT;
                    end
                    else
                    begin
                        entered_reg <= entered_reg || foot_in;
                        if (k_reg == n_reg)
                        begin
                            pend_pass_reg <= entered_reg || foot_in;
                            state_reg     <= S_EMIT;
                        end
                        else
                            state_reg <= S_ADV;
                    end
                end
                S_ADV:
                begin
                    k_reg  <= k_reg + 1'b1;
                    rx_reg <= wrap_x ? (NW+1)'(sum_rx - two_n) : (NW+1)'(sum_rx);
                    ry_reg <= wrap_y ? (NW+1)'(sum_ry - two_n) : (NW+1)'(sum_ry);
                    qx_reg <= qx_reg + stepqx_reg + 18'(wrap_x);
                    qy_reg <= qy_reg + stepqy_reg + 18'(wrap_y);
                    state_reg <= S_FOOT;
                end
                S_EMIT:
                begin
                    // hold until the output register is free
                    if (emit_go)
                    begin
                        result_reg.passes    <= pend_pass_reg;
                        result_reg.was_write <= pend_write_reg;
                        state_reg            <= S_IDLE;
                    end
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

`default_nettype wire

>>> src/pfpc_checker.sv
// ----------------------------------------------------------------------------
// pfpc_checker: port-level checks for the polygon footprint path check
// Watches the item and result channels and flags protocol or result slips.
// ----------------------------------------------------------------------------
`default_nettype none

module pfpc_checker (
    input wire                clk,
    input wire                rst_n,
    input wire                item_valid,
    input wire                item_stall,
    input pfpc_pkg::item_t    item,
    input wire                result_valid,
    input wire                result_stall,
    input pfpc_pkg::result_t  result
);
    import pfpc_pkg::*;

    // a stalled result transaction stays offered
    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid)
        else $error("result dropped while stalled");

    a_result_stable: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> $stable(result))
        else $error("result payload changed while stalled");

    // a write acknowledge never reports a pass
    a_write_no_pass: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> !(result.passes && result.was_write))
        else $error("write acknowledge carries a pass");

    // one transaction in work at a time
    a_one_in_work: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && !item_stall |=> item_stall)
        else $error("item taken while another is in work");

endmodule

bind polygon_footprint_path_check pfpc_checker u_pfpc_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
);

`default_nettype wire
